// ===== design/u8dec_pkg.sv =====
// shared types, constants and the lead byte decode for the utf-8 decoder
// no dependencies
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam logic [20:0] REPL_CP      = 21'h00FFFD;
    localparam logic [20:0] MIN_TWO_CP   = 21'h000080;
    localparam logic [20:0] MIN_THREE_CP = 21'h000800;
    localparam logic [20:0] MIN_FOUR_CP  = 21'h010000;
    localparam logic [20:0] MAX_CP       = 21'h10FFFF;
    localparam logic [20:0] SURR_LO_CP   = 21'h00D800;
    localparam logic [20:0] SURR_HI_CP   = 21'h00DFFF;
    localparam logic [1:0]  CONT_TAG     = 2'b10;
    localparam logic [2:0]  LEAD2_TAG    = 3'b110;
    localparam logic [3:0]  LEAD3_TAG    = 4'b1110;
    localparam logic [4:0]  LEAD4_TAG    = 5'b11110;

    // open multi-byte sequence
    typedef struct packed {
        logic [1:0]  need;
        logic [1:0]  held;
        logic [20:0] partial;
    } seq_t;

    // what one byte leaves for the output side: rep replacements, then one final beat
    typedef struct packed {
        logic        emit;
        logic [1:0]  rep;
        logic [20:0] cp;
        logic        mal;
        logic        last;
    } desc_t;

    typedef struct packed {
        logic        emit;
        logic [20:0] cp;
        logic        mal;
        logic [1:0]  need;
        logic [20:0] val;
    } lead_t;

    function automatic lead_t start_lead(input logic [7:0] b, input logic last);
        lead_t r;
        r      = '0;
        r.cp   = REPL_CP;
        r.mal  = 1'b1;
        if (!b[7])
        begin
            r.emit = 1'b1;
            r.cp   = {13'd0, b};
            r.mal  = 1'b0;
        end
        else if (b[7:5] == LEAD2_TAG)
        begin
            r.need = 2'd1;
            r.val  = {16'd0, b[4:0]};
        end
        else if (b[7:4] == LEAD3_TAG)
        begin
            r.need = 2'd2;
            r.val  = {17'd0, b[3:0]};
        end
        else if (b[7:3] == LEAD4_TAG)
        begin
            r.need = 2'd3;
            r.val  = {18'd0, b[2:0]};
        end
        else
        begin
            r.emit = 1'b1;
        end
        // multi-byte lead that ends the text opens nothing
        if (r.need != 2'd0 && last)
        begin
            r.emit = 1'b1;
            r.need = 2'd0;
            r.val  = '0;
        end
        return r;
    endfunction

endpackage

// ===== design/u8dec_step.sv =====
// per-byte decode: next sequence state and the result descriptor for one byte
// depends on u8dec_pkg
`timescale 1ns / 1ps

module u8dec_step (
    input  logic [7:0]       byte_req,
    input  logic             last_byte,
    input  u8dec_pkg::seq_t  seq_cur,
    output u8dec_pkg::seq_t  seq_next,
    output u8dec_pkg::desc_t desc
);
    import u8dec_pkg::*;

    lead_t       lead;
    logic [20:0] pv;
    logic [1:0]  need_dec;
    logic [1:0]  held_inc;
    logic        bad;

    always_comb
    begin
        lead     = start_lead(byte_req, last_byte);
        pv       = {seq_cur.partial[14:0], byte_req[5:0]};
        need_dec = seq_cur.need - 2'd1;
        held_inc = seq_cur.held + 2'd1;

        unique case (held_inc)
            2'd1:    bad = pv < MIN_TWO_CP;
            2'd2:    bad = pv < MIN_THREE_CP || (pv >= SURR_LO_CP && pv <= SURR_HI_CP);
            2'd3:    bad = pv < MIN_FOUR_CP || pv > MAX_CP;
            default: bad = 1'b1;
        endcase

        seq_next  = seq_cur;
        desc      = '0;
        desc.cp   = REPL_CP;
        desc.mal  = 1'b1;
        desc.last = last_byte;

        if (seq_cur.need != 2'd0)
        begin
            if (byte_req[7:6] == CONT_TAG)
            begin
                if (need_dec == 2'd0)
                begin
                    desc.emit = 1'b1;
                    desc.cp   = bad ? REPL_CP : pv;
                    desc.mal  = bad;
                    seq_next  = '0;
                end
                else if (last_byte)
                begin
                    // lead and every continuation so far, this one as the final beat
                    desc.emit = 1'b1;
                    desc.rep  = held_inc;
                    seq_next  = '0;
                end
                else
                begin
                    seq_next.need    = need_dec;
                    seq_next.held    = held_inc;
                    seq_next.partial = pv;
                end
            end
            else
            begin
                // interrupted sequence, then the byte as a new lead
                desc.emit = 1'b1;
                if (lead.emit)
                begin
                    desc.rep = held_inc;
                    desc.cp  = lead.cp;
                    desc.mal = lead.mal;
                    seq_next = '0;
                end
                else
                begin
                    desc.rep         = seq_cur.held;
                    seq_next.need    = lead.need;
                    seq_next.held    = 2'd0;
                    seq_next.partial = lead.val;
                end
            end
        end
        else
        begin
            if (lead.emit)
            begin
                desc.emit = 1'b1;
                desc.cp   = lead.cp;
                desc.mal  = lead.mal;
            end
            else
            begin
                seq_next.need    = lead.need;
                seq_next.held    = 2'd0;
                seq_next.partial = lead.val;
            end
        end
    end

endmodule

// ===== design/utf8_to_code_point_decoder_core.sv =====
// utf-8 byte stream to unicode code points, U+FFFD for malformed input
// depends on u8dec_pkg and u8dec_step
//
//  channel  | dir | tdata            | tuser                     | tlast
//  s_axis   | in  | [7:0] byte       | -                         | last byte of text
//  m_axis   | out | [20:0] code pt   | [0] malformed [1] end txt | last beat of byte
//
// one byte per cycle when each byte gives at most one beat and m_axis_tready is high
// a byte giving n beats holds the output for all n beats; a buffered byte giving a beat stalls input
// path from input beat to first output beat: input register, then result register
// reset clears the open sequence and both valid flags
// m_axis_tready low holds the result register; s_axis stays ready while the input register is free
`timescale 1ns / 1ps

module utf8_to_code_point_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_req
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_axis_tuser,   // [0] malformed, [1] end_of_text
    output logic        m_axis_tlast
);
    import u8dec_pkg::*;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    seq_t        seq_reg;
    seq_t        seq_next;
    desc_t       desc;

    logic        s2_valid_reg;
    logic [1:0]  s2_rep_reg;
    logic [20:0] s2_cp_reg;
    logic        s2_mal_reg;
    logic        s2_last_reg;

    logic        s2_free;
    logic        s1_adv;
    logic        rep_beat;

    u8dec_step u_step (
        .byte_req  (s1_byte_reg),
        .last_byte (s1_last_reg),
        .seq_cur   (seq_reg),
        .seq_next  (seq_next),
        .desc      (desc)
    );

    assign rep_beat      = s2_rep_reg != 2'd0;
    assign s2_free       = !s2_valid_reg || (m_axis_tready && !rep_beat);
    assign s1_adv        = s1_valid_reg && (!desc.emit || s2_free);
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            seq_reg      <= '0;
            s2_valid_reg <= 1'b0;
            s2_rep_reg   <= 2'd0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s1_adv)
            begin
                seq_reg <= seq_next;
            end
            if (s1_adv && desc.emit)
            begin
                s2_valid_reg <= 1'b1;
                s2_rep_reg   <= desc.rep;
            end
            else if (s2_valid_reg && m_axis_tready)
            begin
                if (rep_beat)
                begin
                    s2_rep_reg <= s2_rep_reg - 2'd1;
                end
                else
                begin
                    s2_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_byte_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
        if (s1_adv && desc.emit)
        begin
            s2_cp_reg   <= desc.cp;
            s2_mal_reg  <= desc.mal;
            s2_last_reg <= desc.last;
        end
    end

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = {3'd0, rep_beat ? REPL_CP : s2_cp_reg};
    assign m_axis_tuser  = {!rep_beat && s2_last_reg, rep_beat || s2_mal_reg};
    assign m_axis_tlast  = !rep_beat;

    // pending replacements only while the result register holds a byte
    a_rep_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s2_rep_reg != 2'd0 |-> s2_valid_reg)
        else $error("replacement count without a held result");

    // open sequence never exceeds four bytes
    a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg.need != 2'd0 |-> ({1'b0, seq_reg.need} + {1'b0, seq_reg.held}) <= 3'd3)
        else $error("open sequence longer than four bytes");

    // clean results are unicode scalars
    a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[20:0] <= MAX_CP
            && !(m_axis_tdata[20:0] >= SURR_LO_CP && m_axis_tdata[20:0] <= SURR_HI_CP))
        else $error("clean beat is not a unicode scalar");

    // end of text leaves no sequence open
    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |=> seq_reg.need == 2'd0)
        else $error("sequence left open after last byte");

endmodule

// ===== bench/utf8_to_code_point_decoder_core_tb.sv =====
// self-checking bench for utf8_to_code_point_decoder_core: directed and random byte streams,
// a per-byte code point predictor with its own sequence state, random stalls on both sides
// depends on u8dec_pkg and the decoder core
`timescale 1ns / 1ps

module utf8_to_code_point_decoder_core_tb;

    import u8dec_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [20:0] cp;
        logic        mal;
        logic        run_end;
        logic        text_end;
    } cp_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] byte_req
    logic        s_axis_tlast = 1'b0;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [20:0] code_point, [23:21] zero
    logic [1:0]  m_axis_tuser;          // [0] malformed, [1] end_of_text
    logic        m_axis_tlast;          // last_of_run

    cp_beat_t    expected_cps[$];
    int          mismatch_count = 0;
    int          byte_count = 0;
    int          cycle_count = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          rx_hold = 0;

    // predictor state
    int          pend_need = 0;
    int          pend_held = 0;
    logic [20:0] pend_val = '0;

    utf8_to_code_point_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic push_cp(input logic [20:0] cp, input logic mal);
        cp_beat_t beat;
        beat = '{cp: cp, mal: mal, run_end: 1'b0, text_end: 1'b0};
        expected_cps.push_back(beat);
    endtask

    task automatic clear_pending();
        pend_need = 0;
        pend_held = 0;
        pend_val  = '0;
    endtask

    // byte seen with no sequence open
    task automatic open_sequence(input logic [7:0] b, input logic lst);
        int          need;
        logic [20:0] val;
        need = 0;
        val  = '0;
        if (b[7] == 1'b0)
            push_cp({13'd0, b}, 1'b0);
        else
        begin
            if (b[7:5] == LEAD2_TAG)
            begin
                need = 1;
                val  = {16'd0, b[4:0]};
            end
            else if (b[7:4] == LEAD3_TAG)
            begin
                need = 2;
                val  = {17'd0, b[3:0]};
            end
            else if (b[7:3] == LEAD4_TAG)
            begin
                need = 3;
                val  = {18'd0, b[2:0]};
            end
            if (need == 0 || lst)
                push_cp(REPL_CP, 1'b1);
            else
            begin
                pend_need = need;
                pend_held = 0;
                pend_val  = val;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic lst);
        int          before_size;
        logic [20:0] v;
        logic        bad;
        cp_beat_t    tail;
        before_size = expected_cps.size();
        if (pend_need != 0)
        begin
            if (b[7:6] == CONT_TAG)
            begin
                v = {pend_val[14:0], b[5:0]};
                pend_val = v;
                pend_need--;
                pend_held++;
                if (pend_need == 0)
                begin
                    if (pend_held == 1)
                        bad = (v < MIN_TWO_CP);
                    else if (pend_held == 2)
                        bad = (v < MIN_THREE_CP) || (v >= SURR_LO_CP && v <= SURR_HI_CP);
                    else
                        bad = (v < MIN_FOUR_CP) || (v > MAX_CP);
                    push_cp(bad ? REPL_CP : v, bad);
                    clear_pending();
                end
                else if (lst)
                begin
                    for (int i = 0; i <= pend_held; i++)
                        push_cp(REPL_CP, 1'b1);
                    clear_pending();
                end
            end
            else
            begin
                for (int i = 0; i <= pend_held; i++)
                    push_cp(REPL_CP, 1'b1);
                clear_pending();
                open_sequence(b, lst);
            end
        end
        else
            open_sequence(b, lst);
        if (expected_cps.size() > before_size)
        begin
            tail = expected_cps.pop_back();
            tail.run_end  = 1'b1;
            tail.text_end = lst;
            expected_cps.push_back(tail);
        end
    endtask

    // called just after a rising edge; returns at the edge that accepts the beat
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_byte(b, lst);
        byte_count++;
    endtask

    // encode v as a len-byte sequence and send the first keep bytes
    task automatic send_seq(input int len, input logic [20:0] v, input int keep,
                            input logic end_text);
        logic [7:0] seq_bytes [4];
        seq_bytes[0] = {1'b0, v[6:0]};
        seq_bytes[1] = {CONT_TAG, v[5:0]};
        seq_bytes[2] = {CONT_TAG, v[5:0]};
        seq_bytes[3] = {CONT_TAG, v[5:0]};
        if (len == 2)
            seq_bytes[0] = {LEAD2_TAG, v[10:6]};
        else if (len == 3)
        begin
            seq_bytes[0] = {LEAD3_TAG, v[15:12]};
            seq_bytes[1] = {CONT_TAG, v[11:6]};
        end
        else if (len == 4)
        begin
            seq_bytes[0] = {LEAD4_TAG, v[20:18]};
            seq_bytes[1] = {CONT_TAG, v[17:12]};
            seq_bytes[2] = {CONT_TAG, v[11:6]};
        end
        for (int i = 0; i < keep; i++)
            send_byte(seq_bytes[i], (i == keep - 1) ? end_text : 1'b0);
    endtask

    // receiver: per-beat stall, optional long hold
    initial
    begin
        int w;
        wait (rst_n == 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            w = rx_idle ? $urandom_range(0, 7) : 0;
            if (w > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cp_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_cps.size() == 0)
                report_mismatch($sformatf("unexpected beat cp %h", m_axis_tdata[20:0]));
            else
            begin
                want = expected_cps.pop_front();
                if (m_axis_tdata[20:0] !== want.cp || m_axis_tuser[0] !== want.mal
                    || m_axis_tlast !== want.run_end || m_axis_tuser[1] !== want.text_end)
                    report_mismatch($sformatf(
                        "cp %h mal %b run_end %b text_end %b, want %h %b %b %b",
                        m_axis_tdata[20:0], m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1],
                        want.cp, want.mal, want.run_end, want.text_end));
            end
        end
    end

    task automatic test_ascii();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_valid_sequences();
        send_seq(2, 21'h000080, 2, 1'b0);
        send_seq(3, 21'h00FFFD, 3, 1'b0);
        send_seq(4, 21'h10FFFF, 4, 1'b1);
    endtask

    task automatic test_range_errors();
        // overlong, surrogate, above the top of the code space
        send_seq(2, 21'h00007F, 2, 1'b0);
        send_seq(3, 21'h00D800, 3, 1'b0);
        send_seq(4, 21'h110000, 4, 1'b0);
    endtask

    task automatic test_bad_leads();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_interrupted();
        send_seq(3, 21'h0020AC, 2, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    task automatic test_early_end();
        send_seq(4, 21'h010000, 2, 1'b1);
        send_seq(2, 21'h0000C3, 1, 1'b1);
    endtask

    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_hold = 80;
        repeat (8)
        begin
            send_seq(3, 21'h000800, 2, 1'b0);
            send_byte(8'hFF, 1'b0);
        end
        tx_idle = 1'b1;
    endtask

    task automatic test_random_text();
        int          target;
        int          kind;
        int          len;
        logic [20:0] v;
        target = byte_count + 250;
        while (byte_count < target)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                tx_idle = 1'($urandom_range(0, 1));
                rx_idle = 1'($urandom_range(0, 1));
            end
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 4);
            v    = 21'($urandom());
            if (kind < 4)
            begin
                if (len == 1)
                    v = 21'($urandom_range(0, 'h7F));
                else if (len == 2)
                    v = 21'($urandom_range('h80, 'h7FF));
                else if (len == 3)
                    v = 21'($urandom_range('h800, 'hFFFF));
                else
                    v = 21'($urandom_range('h10000, 'h10FFFF));
                send_seq(len, v, len, $urandom_range(0, 9) == 0);
            end
            else if (kind < 7)
                send_seq(len, v, len, $urandom_range(0, 9) == 0);
            else if (kind < 9)
                send_seq(len, v, (len > 1) ? $urandom_range(1, len - 1) : 1,
                         $urandom_range(0, 2) == 0);
            else
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ascii();
        test_valid_sequences();
        test_range_errors();
        test_bad_leads();
        test_interrupted();
        test_early_end();
        test_backpressure();
        test_random_text();
        s_axis_tvalid <= 1'b0;
        while (expected_cps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_cps.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== utf8_to_code_point_decoder_core.f =====
design/u8dec_pkg.sv
design/u8dec_step.sv
design/utf8_to_code_point_decoder_core.sv
bench/utf8_to_code_point_decoder_core_tb.sv
